// ===== rtl/imu_fad_pkg.sv =====
// Shared constants and types for the inertial sensor frame align and decode block.
package imu_fad_pkg;

    localparam int FRAME_LEN = 11;
    localparam int POS_W     = 4;
    localparam int IDX_W     = 5;
    localparam int WORD_W    = 16;
    localparam int MUL_W     = 13;
    localparam int VALUE_W   = 28;
    localparam int PROD_W    = WORD_W + MUL_W;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    localparam logic signed [MUL_W-1:0] MUL_ACC   = 13'sd314;
    localparam logic signed [MUL_W-1:0] MUL_RATE  = 13'sd4000;
    localparam logic signed [MUL_W-1:0] MUL_ANGLE = 13'sd360;

    typedef logic [FRAME_LEN-1:0][7:0] t_window;

    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } t_kind;

    typedef struct packed {
        logic              vld;
        t_kind             kind;
        logic [WORD_W-1:0] word_x;
        logic [WORD_W-1:0] word_y;
        logic [WORD_W-1:0] word_z;
    } t_frame;

endpackage

// ===== rtl/imu_fad_align.sv =====
// Header search lanes, lowest-position merge, window rotation and type decode.
module imu_fad_align (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  imu_fad_pkg::t_window  i_win,
    output imu_fad_pkg::t_frame   o_frame
);
    import imu_fad_pkg::*;

    logic [FRAME_LEN-1:0] hit;
    logic                 found;
    logic [POS_W-1:0]     pos;
    logic [IDX_W-1:0]     idx;
    logic [7:0]           al [8];
    logic                 type_ok;
    t_kind                kind;
    t_frame               n_frame;
    t_frame               r_frame;

    for (genvar g = 0; g < FRAME_LEN; g++) begin : g_lane
        assign hit[g] = (i_win[g] == HDR_BYTE);
    end

    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = FRAME_LEN - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = 1'b1;
                pos   = POS_W'(i);
            end
        end
    end

    always_comb begin
        idx = '0;
        for (int k = 0; k < 8; k++) begin
            idx = {1'b0, pos} + IDX_W'(k);
            if (idx >= IDX_W'(FRAME_LEN)) begin
                idx = idx - IDX_W'(FRAME_LEN);
            end
            al[k] = i_win[idx[POS_W-1:0]];
        end
    end

    always_comb begin
        type_ok = 1'b1;
        kind    = KIND_ACC;
        case (al[1])
            TYPE_ACC: begin
                kind = KIND_ACC;
            end
            TYPE_RATE: begin
                kind = KIND_RATE;
            end
            TYPE_ANGLE: begin
                kind = KIND_ANGLE;
            end
            default: begin
                type_ok = 1'b0;
            end
        endcase
        n_frame.vld    = i_start & found & type_ok;
        n_frame.kind   = kind;
        n_frame.word_x = {al[3], al[2]};
        n_frame.word_y = {al[5], al[4]};
        n_frame.word_z = {al[7], al[6]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame.vld <= 1'b0;
        end else begin
            r_frame.vld <= n_frame.vld;
        end
        r_frame.kind   <= n_frame.kind;
        r_frame.word_x <= n_frame.word_x;
        r_frame.word_y <= n_frame.word_y;
        r_frame.word_z <= n_frame.word_z;
    end

    assign o_frame = r_frame;

endmodule

// ===== rtl/imu_fad_axis.sv =====
// One axis lane: scale a signed 16-bit word by the per-kind constant to a Q28.0 signed integer.
module imu_fad_axis (
    input  logic                                i_clk,
    input  imu_fad_pkg::t_kind                  i_kind,
    input  logic [imu_fad_pkg::WORD_W-1:0]      i_word,
    output logic signed [imu_fad_pkg::VALUE_W-1:0] o_value
);
    import imu_fad_pkg::*;

    logic signed [MUL_W-1:0]   coeff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [VALUE_W-1:0] n_value;
    logic signed [VALUE_W-1:0] r_value;

    always_comb begin
        case (i_kind)
            KIND_ACC:   coeff = MUL_ACC;
            KIND_RATE:  coeff = MUL_RATE;
            KIND_ANGLE: coeff = MUL_ANGLE;
            default:    coeff = MUL_ACC;
        endcase
    end

    assign prod    = $signed(i_word) * coeff;
    assign n_value = prod[VALUE_W-1:0];

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/imu_fax_placeholder_unused.sv =====
// Registered result strobe and kind hold between the align stage and the output.
module imu_fax_placeholder_unused (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imu_fad_pkg::t_frame i_frame,
    output logic               o_valid,
    output logic [1:0]         o_kind
);
    import imu_fad_pkg::*;

    logic  r_valid;
    t_kind r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_frame.vld;
        end
        r_kind <= i_frame.kind;
    end

    assign o_valid = r_valid;
    assign o_kind  = 2'(r_kind);

endmodule

// ===== rtl/imu_frame_align_decode_unit.sv =====
// Top level of the inertial sensor frame align and decode block.
// Takes one 11-byte receive window per request, any cycle: o_busy never rises, so a request
// is accepted whenever i_start is high. The window is searched in eleven parallel compare
// lanes for the 0x55 header (lowest position wins), rotated so the header comes first, and
// the type byte picks acceleration, angular rate or angle. Three axis lanes scale the
// little-endian signed words to Q28.0 signed integers with one constant multiply each. A result
// appears on o_valid after the align register and the strobe register, for one cycle; a window
// with no header or an unknown type gives no result. Throughput is one window per cycle, set by
// the registered align and multiply stages. The receiver cannot stall the results.
module imu_frame_align_decode_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic [7:0]                             i_byte_00,
    input  logic [7:0]                             i_byte_01,
    input  logic [7:0]                             i_byte_02,
    input  logic [7:0]                             i_byte_03,
    input  logic [7:0]                             i_byte_04,
    input  logic [7:0]                             i_byte_05,
    input  logic [7:0]                             i_byte_06,
    input  logic [7:0]                             i_byte_07,
    input  logic [7:0]                             i_byte_08,
    input  logic [7:0]                             i_byte_09,
    input  logic [7:0]                             i_byte_10,
    output logic                                   o_valid,
    output logic [1:0]                             o_kind,
    output logic signed [imu_fad_pkg::VALUE_W-1:0] o_value_x,
    output logic signed [imu_fad_pkg::VALUE_W-1:0] o_value_y,
    output logic signed [imu_fad_pkg::VALUE_W-1:0] o_value_z
);
    import imu_fad_pkg::*;

    t_window win;
    t_frame  frame;

    assign win = {i_byte_10, i_byte_09, i_byte_08, i_byte_07, i_byte_06, i_byte_05,
                  i_byte_04, i_byte_03, i_byte_02, i_byte_01, i_byte_00};

    assign o_busy = 1'b0;

    imu_fad_align u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_win   (win),
        .o_frame (frame)
    );

    imu_fad_axis u_axis_x (
        .i_clk   (i_clk),
        .i_kind  (frame.kind),
        .i_word  (frame.word_x),
        .o_value (o_value_x)
    );

    imu_fad_axis u_axis_y (
        .i_clk   (i_clk),
        .i_kind  (frame.kind),
        .i_word  (frame.word_y),
        .o_value (o_value_y)
    );

    imu_fad_axis u_axis_z (
        .i_clk   (i_clk),
        .i_kind  (frame.kind),
        .i_word  (frame.word_z),
        .o_value (o_value_z)
    );

    imu_fax_placeholder_unused u_strobe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame),
        .o_valid (o_valid),
        .o_kind  (o_kind)
    );

    a_valid_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 2))
        else $error("result without a request two cycles earlier");

    a_acc_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ACC) |-> (o_value_x[0] == 1'b0 && o_value_z[0] == 1'b0))
        else $error("acceleration value not a multiple of the scale");

    a_rate_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_RATE) |-> (o_value_y[4:0] == 5'd0))
        else $error("angular rate value not a multiple of the scale");

    a_angle_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ANGLE) |-> (o_value_x[2:0] == 3'd0))
        else $error("angle value not a multiple of the scale");

endmodule
